[rtl/core/bda_pkg.sv]
// Shared types and constants for the debounced button with auto-repeat.
package bda_pkg;

  localparam int CFG_INDEX_BITS = 8;
  localparam int CFG_DATA_BITS  = 16;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_DEBOUNCE_TIME   = 8'd0,
    REG_REPEAT_DELAY    = 8'd1,
    REG_REPEAT_INTERVAL = 8'd2,
    REG_REPEAT_ENABLE   = 8'd3
  } reg_index_t;

  typedef enum logic [1:0] {
    KEY_NONE   = 2'd0,
    KEY_PRESS  = 2'd1,
    KEY_REPEAT = 2'd2
  } event_code_t;

  localparam logic [15:0] DEBOUNCE_TIME_RST   = 16'd30;
  localparam logic [15:0] REPEAT_DELAY_RST    = 16'd500;
  localparam logic [15:0] REPEAT_INTERVAL_RST = 16'd150;

  typedef struct packed {
    logic [15:0] debounce_time;
    logic [15:0] repeat_delay;
    logic [15:0] repeat_interval;
    logic        repeat_enable;
  } bda_cfg_t;

endpackage

[rtl/core/bda_cfg_regs.sv]
// Configuration register file for the debounced button block.
module bda_cfg_regs (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [bda_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
  input  logic [bda_pkg::CFG_DATA_BITS-1:0]    cfg_data,
  output bda_pkg::bda_cfg_t                    cfg
);
  import bda_pkg::*;

  bda_cfg_t cfg_r;
  bda_cfg_t cfg_nxt;

  assign cfg_ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      case (cfg_index)
        REG_DEBOUNCE_TIME:   cfg_nxt.debounce_time   = cfg_data;
        REG_REPEAT_DELAY:    cfg_nxt.repeat_delay    = cfg_data;
        REG_REPEAT_INTERVAL: cfg_nxt.repeat_interval = cfg_data;
        REG_REPEAT_ENABLE:   cfg_nxt.repeat_enable   = cfg_data[0];
        default:             cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.debounce_time   <= DEBOUNCE_TIME_RST;
      cfg_r.repeat_delay    <= REPEAT_DELAY_RST;
      cfg_r.repeat_interval <= REPEAT_INTERVAL_RST;
      cfg_r.repeat_enable   <= 1'b1;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

[rtl/core/bda_eval.sv]
// Debounce and auto-repeat state with the per-sample event decision.
module bda_eval #(
  parameter int TIME_BITS = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  fire,
  input  logic [TIME_BITS-1:0]  now,
  input  logic                  raw,
  input  bda_pkg::bda_cfg_t     cfg,
  output bda_pkg::event_code_t  code
);
  import bda_pkg::*;

  logic                 last_raw_r,     last_raw_nxt;
  logic                 stable_r,       stable_nxt;
  logic [TIME_BITS-1:0] change_time_r,  change_time_nxt;
  logic [TIME_BITS-1:0] press_time_r,   press_time_nxt;
  logic [TIME_BITS-1:0] repeat_time_r,  repeat_time_nxt;

  logic [TIME_BITS-1:0] since_change;
  logic [TIME_BITS-1:0] since_press;
  logic [TIME_BITS-1:0] since_repeat;
  logic                 settle;
  logic                 press;
  logic                 repeat_hit;

  // Differences wrap naturally at the state width.
  always_comb begin
    change_time_nxt = (raw != last_raw_r) ? now : change_time_r;
    last_raw_nxt    = raw;
    since_change    = now - change_time_nxt;
    since_press     = now - press_time_r;
    since_repeat    = now - repeat_time_r;
    settle          = (since_change >= TIME_BITS'(cfg.debounce_time)) && (raw != stable_r);
    press           = settle && !raw;
    stable_nxt      = settle ? raw : stable_r;
    // A press or a release sample never carries a repeat as well.
    repeat_hit      = !settle && cfg.repeat_enable && !stable_r &&
                      (since_press  >= TIME_BITS'(cfg.repeat_delay)) &&
                      (since_repeat >= TIME_BITS'(cfg.repeat_interval));
    press_time_nxt  = press ? now : press_time_r;
    repeat_time_nxt = (press || repeat_hit) ? now : repeat_time_r;
  end

  always_comb begin
    if (press) begin
      code = KEY_PRESS;
    end else if (repeat_hit) begin
      code = KEY_REPEAT;
    end else begin
      code = KEY_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_raw_r    <= 1'b1;
      stable_r      <= 1'b1;
      change_time_r <= '0;
      press_time_r  <= '0;
      repeat_time_r <= '0;
    end else if (fire) begin
      last_raw_r    <= last_raw_nxt;
      stable_r      <= stable_nxt;
      change_time_r <= change_time_nxt;
      press_time_r  <= press_time_nxt;
      repeat_time_r <= repeat_time_nxt;
    end
  end

endmodule

[rtl/core/button_debounce_autorepeat.sv]
// Top level: input register, event evaluation and result register.
// A sample is held in the input register, then its event code in the result register.
// Throughput: one sample per cycle while the result is taken; bda_eval updates its state on each fired sample.
// A stalled result holds the pipeline; both stages advance together once it is taken.
// Reset (synchronous, active low) empties both stages, sets the button released with
// all timestamps at zero and loads the registers with 30, 500, 150 and enable set.
module button_debounce_autorepeat #(
  parameter int TIME_BITS = 32
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [31:0]                         in_now_ms,
  input  logic                                in_raw_level,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [1:0]                          out_event_code,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [bda_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
  input  logic [bda_pkg::CFG_DATA_BITS-1:0]   cfg_data
);
  import bda_pkg::*;

  bda_cfg_t    cfg;
  event_code_t code;

  logic        s1_valid_r, s1_valid_nxt;
  logic [31:0] s1_now_r;
  logic        s1_raw_r;
  logic        out_valid_r, out_valid_nxt;
  event_code_t out_code_r;
  logic        advance;
  logic        fire;
  logic        in_fire;

  // The pipeline moves whenever the result register is free or being emptied.
  assign advance  = !out_valid_r || out_ready;
  assign fire     = s1_valid_r && advance;
  assign in_ready = !s1_valid_r || advance;
  assign in_fire  = in_valid && in_ready;

  assign s1_valid_nxt  = in_fire ? 1'b1 : (fire ? 1'b0 : s1_valid_r);
  assign out_valid_nxt = fire ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);

  bda_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  bda_eval #(
    .TIME_BITS (TIME_BITS)
  ) u_eval (
    .clk   (clk),
    .rst_n (rst_n),
    .fire  (fire),
    .now   (TIME_BITS'(s1_now_r)),
    .raw   (s1_raw_r),
    .cfg   (cfg),
    .code  (code)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_now_r <= in_now_ms;
      s1_raw_r <= in_raw_level;
    end
    if (fire) begin
      out_code_r <= code;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_event_code = out_code_r;

endmodule
